@@ rtl/core/vertex_normal_accumulator_assert.svh @@
// assertion macros used by the rtl
`ifndef VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH
`define VERTEX_NORMAL_ACCUMULATOR_ASSERT_SVH

// same-cycle implication
`define VNA_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define VNA_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/core/vna_pkg.sv @@
package vna_pkg;

    // input mode codes
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_FACE = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam int POS_W   = 48;
    localparam int DIFF_W  = 17;
    localparam int PROD_W  = 34;
    localparam int CROSS_W = 35;
    localparam int Q_W     = 16;
    localparam int OUT_W   = 40;
    localparam int IN_DW   = 80;
    localparam int OUT_DW  = 136;

    localparam logic [Q_W-1:0] ONE_Q14 = 16'd16384;

    typedef enum logic [2:0] {
        CMD_LOAD = 3'b001,
        CMD_FACE = 3'b010,
        CMD_READ = 3'b100
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               in_range;
        logic [7:0]         index;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [7:0]         ca;
        logic [7:0]         cb;
        logic [7:0]         cc;
    } cmd_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] qx;
        logic [Q_W-1:0] qy;
        logic [Q_W-1:0] qz;
    } norm_rsp_t;

    typedef struct packed {
        logic idle;
        logic norm_wait;
    } back_stat_t;

endpackage

@@ rtl/core/vertex_normal_accumulator.sv @@
// Area-weighted vertex normal accumulator. Load transactions store a signed
// Q7.8 vertex position and clear its sums; face transactions add the cross
// product (Pb-Pa)x(Pc-Pa) into the saturating sums of all three corners; read
// transactions return the sums of one vertex, raw or as a Q1.14 unit vector
// when normalize is enabled through the cfg port. The front end takes input
// transactions into a two-entry command queue while the back end works, so
// the input side stalls only when two commands wait. Each command runs alone
// in the back end, timed by the position and sum memories (one write port and
// one registered read port each) and a shared multiplier. A normalized read
// adds the iterative normalizer: it shifts the sums down until they fit in 30
// bits, sums the squares, takes the integer square root and then divides each
// component by the length. Memory contents are not cleared by reset; vertices
// must be loaded before use.
`include "vertex_normal_accumulator_assert.svh"

module vertex_normal_accumulator #(
    parameter int MAX_VERTICES = 256,
    parameter int SUM_WIDTH    = 40
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    // vertex_index, coord_x, coord_y, coord_z, corner_a, corner_b, corner_c
    input  logic [79:0]   s_tdata,
    // mode
    input  logic [1:0]    s_tuser,
    output logic          m_tvalid,
    input  logic          m_tready,
    // normal_x, normal_y, normal_z, read_index, saturated, zero fill
    output logic [135:0]  m_tdata,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic          cfg_data
);
    import vna_pkg::*;

    logic                        norm_en_reg;
    logic                        cmd_valid, cmd_ready;
    cmd_t                        cmd;
    logic                        norm_start;
    logic signed [SUM_WIDTH-1:0] norm_sx, norm_sy, norm_sz;
    norm_rsp_t                   norm_rsp;
    back_stat_t                  back_stat;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_en_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            norm_en_reg <= cfg_data;
        end
    end

    vna_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    vna_norm #(.SUM_WIDTH(SUM_WIDTH)) u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .sx    (norm_sx),
        .sy    (norm_sy),
        .sz    (norm_sz),
        .rsp   (norm_rsp)
    );

    vna_back #(.MAX_VERTICES(MAX_VERTICES), .SUM_WIDTH(SUM_WIDTH)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .norm_enable (norm_en_reg),
        .norm_start  (norm_start),
        .norm_sx     (norm_sx),
        .norm_sy     (norm_sy),
        .norm_sz     (norm_sz),
        .norm_rsp    (norm_rsp),
        .stat        (back_stat),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // normalizer finishes only while the back end waits for it
    `VNA_ASSERT_IMP(a_norm_done_waited, clk, rst_n, norm_rsp.done, back_stat.norm_wait, "normalizer done while back end not waiting")
    // unit vector components never exceed one in Q1.14
    `VNA_ASSERT_IMP(a_norm_range, clk, rst_n, norm_rsp.done, (norm_rsp.qx <= ONE_Q14) && (norm_rsp.qy <= ONE_Q14) && (norm_rsp.qz <= ONE_Q14), "normalized component above one")
    // a normalize run never completes the cycle after it starts
    `VNA_ASSERT_NEXT(a_norm_not_instant, clk, rst_n, norm_start, !norm_rsp.done, "normalizer done right after start")

endmodule

@@ rtl/core/vna_ram.sv @@
module vna_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/vna_front.sv @@
module vna_front #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [vna_pkg::IN_DW-1:0]     s_tdata,
    input  logic [1:0]                    s_tuser,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output vna_pkg::cmd_t                 cmd
);
    import vna_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       item;
    logic       keep;
    logic       push, pop;

    function automatic logic in_range(input logic [7:0] idx);
        in_range = ({24'd0, idx} < 32'(MAX_VERTICES));
    endfunction

    // unpack and classify the incoming transaction
    always_comb
    begin
        item.index = s_tdata[7:0];
        item.x     = s_tdata[23:8];
        item.y     = s_tdata[39:24];
        item.z     = s_tdata[55:40];
        item.ca    = s_tdata[63:56];
        item.cb    = s_tdata[71:64];
        item.cc    = s_tdata[79:72];
        item.in_range = in_range(s_tdata[7:0]);
        item.kind  = CMD_READ;
        keep       = 1'b0;
        case (s_tuser)
            MODE_LOAD:
            begin
                item.kind = CMD_LOAD;
                keep      = item.in_range;
            end
            MODE_FACE:
            begin
                item.kind = CMD_FACE;
                keep      = in_range(item.ca) && in_range(item.cb) && in_range(item.cc);
            end
            MODE_READ:
            begin
                item.kind = CMD_READ;
                keep      = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    // two-entry command queue
    assign s_tready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign push      = s_tvalid && s_tready && keep;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

@@ rtl/core/vna_norm.sv @@
module vna_norm #(
    parameter int SUM_WIDTH = 40
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [SUM_WIDTH-1:0] sx,
    input  logic signed [SUM_WIDTH-1:0] sy,
    input  logic signed [SUM_WIDTH-1:0] sz,
    output vna_pkg::norm_rsp_t          rsp
);
    import vna_pkg::*;

    localparam int SW = SUM_WIDTH;

    typedef enum logic [6:0] {
        N_IDLE  = 7'b0000001,
        N_SHIFT = 7'b0000010,
        N_SQ    = 7'b0000100,
        N_SQRT  = 7'b0001000,
        N_DSET  = 7'b0010000,
        N_DIV   = 7'b0100000,
        N_DONE  = 7'b1000000
    } norm_state_t;

    norm_state_t     state_reg, state_next;
    logic [SW-1:0]   m_reg [3];
    logic [SW-1:0]   m_next [3];
    logic [1:0]      idx_reg, idx_next;
    logic [59:0]     prod_reg, prod_next;
    logic [61:0]     sq_reg, sq_next;
    logic [61:0]     n_reg, n_next;
    logic [61:0]     r_reg, r_next;
    logic [61:0]     bit_reg, bit_next;
    logic [30:0]     len_reg, len_next;
    logic [47:0]     rem_reg, rem_next;
    logic [3:0]      dbit_reg, dbit_next;
    logic [Q_W-1:0]  q_reg [3];
    logic [Q_W-1:0]  q_next [3];
    logic [Q_W-1:0]  qacc_reg, qacc_next;
    logic [SW-1:0]   m_sel;
    logic [61:0]     trial;
    logic [47:0]     dsh;
    logic            wide;

    // operand select shared by the square and divide phases
    always_comb
    begin
        case (idx_reg)
            2'd0:    m_sel = m_reg[0];
            2'd1:    m_sel = m_reg[1];
            default: m_sel = m_reg[2];
        endcase
    end

    assign wide  = (|m_reg[0][SW-1:30]) || (|m_reg[1][SW-1:30]) || (|m_reg[2][SW-1:30]);
    assign trial = r_reg + bit_reg;
    assign dsh   = {16'd0, len_reg, 1'b0} << dbit_reg;

    always_comb
    begin
        state_next = state_reg;
        m_next     = m_reg;
        idx_next   = idx_reg;
        prod_next  = prod_reg;
        sq_next    = sq_reg;
        n_next     = n_reg;
        r_next     = r_reg;
        bit_next   = bit_reg;
        len_next   = len_reg;
        rem_next   = rem_reg;
        dbit_next  = dbit_reg;
        q_next     = q_reg;
        qacc_next  = qacc_reg;
        case (state_reg)
            // take magnitudes
            N_IDLE:
            begin
                if (start)
                begin
                    m_next[0]  = sx[SW-1] ? SW'(-sx) : SW'(sx);
                    m_next[1]  = sy[SW-1] ? SW'(-sy) : SW'(sy);
                    m_next[2]  = sz[SW-1] ? SW'(-sz) : SW'(sz);
                    state_next = N_SHIFT;
                end
            end
            // scale down until all fit in 30 bits
            N_SHIFT:
            begin
                if (wide)
                begin
                    m_next[0] = m_reg[0] >> 1;
                    m_next[1] = m_reg[1] >> 1;
                    m_next[2] = m_reg[2] >> 1;
                end
                else
                begin
                    idx_next   = 2'd0;
                    sq_next    = '0;
                    state_next = N_SQ;
                end
            end
            // sum of squares, one product a cycle
            N_SQ:
            begin
                if (idx_reg != 2'd3)
                begin
                    prod_next = m_sel[29:0] * m_sel[29:0];
                end
                if (idx_reg != 2'd0)
                begin
                    sq_next = sq_reg + 62'(prod_reg);
                end
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3)
                begin
                    n_next     = sq_next;
                    r_next     = '0;
                    bit_next   = 62'd1 << 60;
                    state_next = N_SQRT;
                end
            end
            // integer square root, one result bit a cycle
            N_SQRT:
            begin
                if (n_reg >= trial)
                begin
                    n_next = n_reg - trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg[0])
                begin
                    len_next = r_next[30:0];
                    idx_next = 2'd0;
                    if (r_next == '0)
                    begin
                        q_next[0]  = '0;
                        q_next[1]  = '0;
                        q_next[2]  = '0;
                        state_next = N_DONE;
                    end
                    else
                    begin
                        state_next = N_DSET;
                    end
                end
            end
            // rounded quotient numerator
            N_DSET:
            begin
                rem_next   = {3'd0, m_sel[29:0], 15'd0} + 48'(len_reg);
                dbit_next  = 4'd15;
                qacc_next  = '0;
                state_next = N_DIV;
            end
            // restoring divide, one quotient bit a cycle
            N_DIV:
            begin
                if (rem_reg >= dsh)
                begin
                    rem_next = rem_reg - dsh;
                    qacc_next[dbit_reg] = 1'b1;
                end
                dbit_next = dbit_reg - 4'd1;
                if (dbit_reg == 4'd0)
                begin
                    q_next[idx_reg] = (qacc_next > ONE_Q14) ? ONE_Q14 : qacc_next;
                    idx_next        = idx_reg + 2'd1;
                    state_next      = (idx_reg == 2'd2) ? N_DONE : N_DSET;
                end
            end
            N_DONE:
            begin
                state_next = N_IDLE;
            end
            default:
            begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        idx_reg  <= idx_next;
        prod_reg <= prod_next;
        sq_reg   <= sq_next;
        n_reg    <= n_next;
        r_reg    <= r_next;
        bit_reg  <= bit_next;
        len_reg  <= len_next;
        rem_reg  <= rem_next;
        dbit_reg <= dbit_next;
        q_reg    <= q_next;
        qacc_reg <= qacc_next;
    end

    assign rsp.done = (state_reg == N_DONE);
    assign rsp.qx   = q_reg[0];
    assign rsp.qy   = q_reg[1];
    assign rsp.qz   = q_reg[2];

endmodule

@@ rtl/core/vna_back.sv @@
module vna_back #(
    parameter int MAX_VERTICES = 256,
    parameter int SUM_WIDTH    = 40
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  vna_pkg::cmd_t                cmd,
    input  logic                         norm_enable,
    output logic                         norm_start,
    output logic signed [SUM_WIDTH-1:0]  norm_sx,
    output logic signed [SUM_WIDTH-1:0]  norm_sy,
    output logic signed [SUM_WIDTH-1:0]  norm_sz,
    input  vna_pkg::norm_rsp_t           norm_rsp,
    output vna_pkg::back_stat_t          stat,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [vna_pkg::OUT_DW-1:0]   m_tdata
);
    import vna_pkg::*;

    localparam int SW = SUM_WIDTH;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int RW = 3 * SW + 1;

    typedef enum logic [13:0] {
        B_IDLE = 14'b00000000000001,
        B_PA   = 14'b00000000000010,
        B_PB   = 14'b00000000000100,
        B_PC   = 14'b00000000001000,
        B_PW   = 14'b00000000010000,
        B_DIFF = 14'b00000000100000,
        B_MUL  = 14'b00000001000000,
        B_ACC  = 14'b00000010000000,
        B_SRD  = 14'b00000100000000,
        B_SWR  = 14'b00001000000000,
        B_RRD  = 14'b00010000000000,
        B_RCAP = 14'b00100000000000,
        B_NORM = 14'b01000000000000,
        B_OUT  = 14'b10000000000000
    } back_state_t;

    back_state_t                state_reg, state_next;
    cmd_t                       cmd_reg;
    logic [POS_W-1:0]           pa_reg, pb_reg, pc_reg;
    logic signed [DIFF_W-1:0]   u_reg [3];
    logic signed [DIFF_W-1:0]   w_reg [3];
    logic [2:0]                 mcnt_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [CROSS_W-1:0]  f_reg [3];
    logic [1:0]                 ccnt_reg;
    logic signed [SW-1:0]       s_reg [3];
    logic                       sat_reg;
    logic signed [OUT_W-1:0]    res_reg [3];
    logic                       start_reg;
    logic                       tvalid_reg;
    logic [OUT_DW-1:0]          tdata_reg;

    logic                       pos_we, sum_we;
    logic [AW-1:0]              pos_waddr, pos_raddr, sum_waddr, sum_raddr;
    logic [POS_W-1:0]           pos_wdata, pos_rdata;
    logic [RW-1:0]              sum_wdata, sum_rdata;
    logic [7:0]                 corner;
    logic signed [DIFF_W-1:0]   op_a, op_b;
    logic signed [SW-1:0]       acc_new [3];
    logic [2:0]                 acc_ov;
    logic                       out_free;

    vna_ram #(.WIDTH(POS_W), .DEPTH(MAX_VERTICES)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vna_ram #(.WIDTH(RW), .DEPTH(MAX_VERTICES)) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    // corner of the current accumulate step
    always_comb
    begin
        case (ccnt_reg)
            2'd0:    corner = cmd_reg.ca;
            2'd1:    corner = cmd_reg.cb;
            default: corner = cmd_reg.cc;
        endcase
    end

    // cross product operand pairs
    always_comb
    begin
        case (mcnt_reg)
            3'd0:    begin op_a = u_reg[1]; op_b = w_reg[2]; end
            3'd1:    begin op_a = u_reg[2]; op_b = w_reg[1]; end
            3'd2:    begin op_a = u_reg[2]; op_b = w_reg[0]; end
            3'd3:    begin op_a = u_reg[0]; op_b = w_reg[2]; end
            3'd4:    begin op_a = u_reg[0]; op_b = w_reg[1]; end
            default: begin op_a = u_reg[1]; op_b = w_reg[0]; end
        endcase
    end

    // saturating accumulate of the face vector
    always_comb
    begin
        logic signed [SW:0] ext;
        for (int i = 0; i < 3; i++)
        begin
            ext = (SW+1)'($signed(sum_rdata[i*SW +: SW])) + (SW+1)'(f_reg[i]);
            acc_ov[i] = (ext[SW] != ext[SW-1]);
            if (acc_ov[i])
            begin
                acc_new[i] = ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
            end
            else
            begin
                acc_new[i] = ext[SW-1:0];
            end
        end
    end

    // memory ports
    always_comb
    begin
        pos_we    = (state_reg == B_IDLE) && cmd_valid && (cmd.kind == CMD_LOAD);
        pos_waddr = AW'(cmd.index);
        pos_wdata = {cmd.z, cmd.y, cmd.x};
        case (state_reg)
            B_PB:    pos_raddr = AW'(cmd_reg.cb);
            B_PC:    pos_raddr = AW'(cmd_reg.cc);
            default: pos_raddr = AW'(cmd_reg.ca);
        endcase
        sum_raddr = (state_reg == B_RRD) ? AW'(cmd_reg.index) : AW'(corner);
        if (state_reg == B_SWR)
        begin
            sum_we    = 1'b1;
            sum_waddr = AW'(corner);
            sum_wdata = {sum_rdata[3*SW] | (|acc_ov), acc_new[2], acc_new[1], acc_new[0]};
        end
        else
        begin
            sum_we    = pos_we;
            sum_waddr = AW'(cmd.index);
            sum_wdata = '0;
        end
    end

    assign out_free = !tvalid_reg || m_tready;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_FACE: state_next = B_PA;
                        CMD_READ: state_next = B_RRD;
                        default:  state_next = B_IDLE;
                    endcase
                end
            end
            B_PA:   state_next = B_PB;
            B_PB:   state_next = B_PC;
            B_PC:   state_next = B_PW;
            B_PW:   state_next = B_DIFF;
            B_DIFF: state_next = B_MUL;
            B_MUL:  state_next = B_ACC;
            B_ACC:  state_next = (mcnt_reg == 3'd5) ? B_SRD : B_MUL;
            B_SRD:  state_next = B_SWR;
            B_SWR:  state_next = (ccnt_reg == 2'd2) ? B_IDLE : B_SRD;
            B_RRD:  state_next = B_RCAP;
            B_RCAP: state_next = norm_enable ? B_NORM : B_OUT;
            B_NORM: state_next = norm_rsp.done ? B_OUT : B_NORM;
            B_OUT:  state_next = out_free ? B_IDLE : B_OUT;
            default: state_next = B_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= B_IDLE;
            start_reg  <= 1'b0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= (state_reg == B_RCAP) && norm_enable;
            if ((state_reg == B_OUT) && out_free)
            begin
                tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                tvalid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                cmd_reg  <= cmd;
                mcnt_reg <= 3'd0;
                ccnt_reg <= 2'd0;
            end
            B_PB: pa_reg <= pos_rdata;
            B_PC: pb_reg <= pos_rdata;
            B_PW: pc_reg <= pos_rdata;
            B_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    u_reg[i] <= DIFF_W'($signed(pb_reg[i*16 +: 16]))
                              - DIFF_W'($signed(pa_reg[i*16 +: 16]));
                    w_reg[i] <= DIFF_W'($signed(pc_reg[i*16 +: 16]))
                              - DIFF_W'($signed(pa_reg[i*16 +: 16]));
                end
            end
            B_MUL: prod_reg <= op_a * op_b;
            B_ACC:
            begin
                if (mcnt_reg[0])
                begin
                    f_reg[mcnt_reg[2:1]] <= f_reg[mcnt_reg[2:1]] - CROSS_W'(prod_reg);
                end
                else
                begin
                    f_reg[mcnt_reg[2:1]] <= CROSS_W'(prod_reg);
                end
                mcnt_reg <= mcnt_reg + 3'd1;
            end
            B_SWR: ccnt_reg <= ccnt_reg + 2'd1;
            B_RCAP:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    s_reg[i]   <= cmd_reg.in_range ? $signed(sum_rdata[i*SW +: SW]) : '0;
                    res_reg[i] <= cmd_reg.in_range
                                ? OUT_W'($signed(sum_rdata[i*SW +: SW])) : '0;
                end
                sat_reg <= cmd_reg.in_range && sum_rdata[3*SW];
            end
            B_NORM:
            begin
                if (norm_rsp.done)
                begin
                    res_reg[0] <= s_reg[0][SW-1] ? -OUT_W'(norm_rsp.qx) : OUT_W'(norm_rsp.qx);
                    res_reg[1] <= s_reg[1][SW-1] ? -OUT_W'(norm_rsp.qy) : OUT_W'(norm_rsp.qy);
                    res_reg[2] <= s_reg[2][SW-1] ? -OUT_W'(norm_rsp.qz) : OUT_W'(norm_rsp.qz);
                end
            end
            default:
            begin
            end
        endcase
        if ((state_reg == B_OUT) && out_free)
        begin
            tdata_reg <= {7'd0, sat_reg, cmd_reg.index, res_reg[2], res_reg[1], res_reg[0]};
        end
    end

    assign cmd_ready      = (state_reg == B_IDLE);
    assign norm_start     = start_reg;
    assign norm_sx        = s_reg[0];
    assign norm_sy        = s_reg[1];
    assign norm_sz        = s_reg[2];
    assign stat.idle      = (state_reg == B_IDLE);
    assign stat.norm_wait = (state_reg == B_NORM);
    assign m_tvalid       = tvalid_reg;
    assign m_tdata        = tdata_reg;

endmodule

@@ tb/vertex_normal_accumulator_tb.sv @@
`timescale 1ns / 1ps

module vertex_normal_accumulator_tb;
    import vna_pkg::*;

    localparam int           CLK_HALF     = 5;
    localparam int           IDLE_LIMIT   = 20000;
    localparam int           DRAIN_CYCLES = 200;
    localparam longint       SUM_HI       = (64'sd1 <<< 39) - 1;
    localparam longint       SUM_LO       = -SUM_HI - 1;
    localparam logic [1:0]   MODE_SPARE   = 2'd3;

    typedef struct {
        logic [39:0] nx;
        logic [39:0] ny;
        logic [39:0] nz;
        logic [7:0]  index;
        logic        sat;
    } normal_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [79:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic         cfg_data = 1'b0;

    // predictor state
    logic signed [15:0] vert_x [256];
    logic signed [15:0] vert_y [256];
    logic signed [15:0] vert_z [256];
    longint             acc_x [256];
    longint             acc_y [256];
    longint             acc_z [256];
    logic               acc_sat [256];
    logic               vert_loaded [256] = '{default: 1'b0};
    logic               unit_mode = 1'b0;

    normal_t pending_normals [$];
    int      error_count = 0;
    int      idle_cycles = 0;
    int      tx_idle_pct = 21;
    int      rx_stall_pct = 78;

    vertex_normal_accumulator uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // saturating add into one accumulator
    function automatic longint sat_sum(input longint acc, input longint f, inout logic mark);
        if (f > 0 && acc > SUM_HI - f)
        begin
            mark = 1'b1;
            return SUM_HI;
        end
        if (f < 0 && acc < SUM_LO - f)
        begin
            mark = 1'b1;
            return SUM_LO;
        end
        return acc + f;
    endfunction

    // scale a sum vector to unit length in q1.14
    task automatic unit_vector(input longint sv [3], output longint ov [3]);
        longint unsigned m [3];
        longint unsigned mx, sq, len, n, bitv, q;
        int k;
        sq = 0;
        k = 0;
        for (int i = 0; i < 3; i++)
            m[i] = (sv[i] < 0) ? longint'(0) - sv[i] : sv[i];
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        while ((mx >> k) >= (64'd1 << 30)) k++;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = m[i] >> k;
            sq += m[i] * m[i];
        end
        // integer square root, bit by bit
        n = sq;
        len = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= len + bitv)
            begin
                n -= len + bitv;
                len = (len >> 1) + bitv;
            end
            else
                len >>= 1;
            bitv >>= 2;
        end
        for (int i = 0; i < 3; i++)
        begin
            if (len == 0)
                ov[i] = 0;
            else
            begin
                q = (2 * m[i] * 16384 + len) / (2 * len);
                if (q > 16384) q = 16384;
                ov[i] = (sv[i] < 0) ? -longint'(q) : longint'(q);
            end
        end
    endtask

    // update the predictor for one accepted transaction
    task automatic predict_item(input logic [1:0] mode, input logic [79:0] d);
        logic [7:0] vi;
        logic [7:0] cn [3];
        longint ux, uy, uz, wx, wy, wz, fx, fy, fz;
        longint sv [3];
        longint ov [3];
        normal_t res;
        vi = d[7:0];
        cn[0] = d[63:56];
        cn[1] = d[71:64];
        cn[2] = d[79:72];
        case (mode)
            MODE_LOAD:
            begin
                vert_x[vi] = d[23:8];
                vert_y[vi] = d[39:24];
                vert_z[vi] = d[55:40];
                acc_x[vi] = 0;
                acc_y[vi] = 0;
                acc_z[vi] = 0;
                acc_sat[vi] = 1'b0;
            end
            MODE_FACE:
            begin
                ux = longint'(vert_x[cn[1]]) - vert_x[cn[0]];
                uy = longint'(vert_y[cn[1]]) - vert_y[cn[0]];
                uz = longint'(vert_z[cn[1]]) - vert_z[cn[0]];
                wx = longint'(vert_x[cn[2]]) - vert_x[cn[0]];
                wy = longint'(vert_y[cn[2]]) - vert_y[cn[0]];
                wz = longint'(vert_z[cn[2]]) - vert_z[cn[0]];
                fx = uy * wz - uz * wy;
                fy = uz * wx - ux * wz;
                fz = ux * wy - uy * wx;
                for (int i = 0; i < 3; i++)
                begin
                    acc_x[cn[i]] = sat_sum(acc_x[cn[i]], fx, acc_sat[cn[i]]);
                    acc_y[cn[i]] = sat_sum(acc_y[cn[i]], fy, acc_sat[cn[i]]);
                    acc_z[cn[i]] = sat_sum(acc_z[cn[i]], fz, acc_sat[cn[i]]);
                end
            end
            MODE_READ:
            begin
                sv[0] = acc_x[vi];
                sv[1] = acc_y[vi];
                sv[2] = acc_z[vi];
                if (unit_mode)
                    unit_vector(sv, ov);
                else
                    ov = sv;
                res.nx = ov[0][39:0];
                res.ny = ov[1][39:0];
                res.nz = ov[2][39:0];
                res.index = vi;
                res.sat = acc_sat[vi];
                pending_normals.push_back(res);
            end
            default: ;
        endcase
    endtask

    // send one input transaction with random idle cycles in front
    task automatic send_item(input logic [1:0] mode, input logic [79:0] d);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= mode;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        predict_item(mode, d);
        if (mode == MODE_LOAD)
            vert_loaded[d[7:0]] = 1'b1;
    endtask

    task automatic send_load(input logic [7:0] vi, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
        send_item(MODE_LOAD, {8'($urandom), 8'($urandom), 8'($urandom), z, y, x, vi});
    endtask

    task automatic send_face(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        send_item(MODE_FACE, {c, b, a, 16'($urandom), 16'($urandom), 16'($urandom),
                              8'($urandom)});
    endtask

    task automatic send_read(input logic [7:0] vi);
        send_item(MODE_READ, {24'($urandom), 48'($urandom) ^ {16'($urandom), 32'h0}, vi});
    endtask

    // wait until the block is quiet, then write the normalize register
    task automatic write_normalize(input logic value);
        s_tvalid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        unit_mode = value;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            1: return 16'($signed($urandom_range(0, 512)) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] rand_loaded();
        logic [7:0] v;
        do
            v = 8'($urandom);
        while (!vert_loaded[v]);
        return v;
    endfunction

    // check each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        normal_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_normals.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = pending_normals.pop_front();
                if (m_tdata[39:0] !== want.nx)
                    report_mismatch($sformatf("normal_x %h want %h", m_tdata[39:0], want.nx));
                if (m_tdata[79:40] !== want.ny)
                    report_mismatch($sformatf("normal_y %h want %h", m_tdata[79:40], want.ny));
                if (m_tdata[119:80] !== want.nz)
                    report_mismatch($sformatf("normal_z %h want %h", m_tdata[119:80], want.nz));
                if (m_tdata[127:120] !== want.index)
                    report_mismatch($sformatf("read_index %h want %h", m_tdata[127:120],
                                              want.index));
                if (m_tdata[128] !== want.sat)
                    report_mismatch($sformatf("saturated %b want %b", m_tdata[128], want.sat));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // watchdog on cycles with no transaction anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // extremes, repeated corners, raw reads and the spare mode
    task automatic test_directed_raw();
        write_normalize(1'b0);
        send_load(8'd0, 16'h8000, 16'h8000, 16'h8000);
        send_load(8'd255, 16'h7fff, 16'h8000, 16'h0000);
        send_load(8'd170, 16'h8000, 16'h7fff, 16'h7fff);
        send_load(8'd85, 16'h0100, 16'hff00, 16'h0080);
        send_read(8'd0);
        send_face(8'd0, 8'd255, 8'd170);
        send_face(8'd255, 8'd170, 8'd85);
        send_face(8'd85, 8'd85, 8'd0);
        send_face(8'd170, 8'd170, 8'd170);
        send_item(MODE_SPARE, 80'($urandom));
        send_read(8'd0);
        send_read(8'd255);
        send_read(8'd170);
        send_read(8'd85);
        send_load(8'd85, 16'h0000, 16'h0000, 16'h0000);
        send_read(8'd85);
    endtask

    // drive one vertex set into positive and then negative saturation
    task automatic test_saturation();
        for (int pass = 0; pass < 2; pass++)
        begin
            send_load(8'd10, 16'h8000, 16'h8000, 16'h0000);
            send_load(8'd11, 16'h7fff, 16'h8000, 16'h0000);
            send_load(8'd12, 16'h8000, 16'h7fff, 16'h0000);
            for (int i = 0; i < 130; i++)
            begin
                if (pass == 0)
                    send_face(8'd10, 8'd11, 8'd12);
                else
                    send_face(8'd10, 8'd12, 8'd11);
            end
            send_read(8'd10);
            send_read(8'd11);
            send_read(8'd12);
        end
    endtask

    // unit-length reads, zero vector included
    task automatic test_normalized();
        write_normalize(1'b1);
        send_read(8'd0);
        send_read(8'd255);
        send_read(8'd170);
        send_read(8'd85);
        send_read(8'd10);
        send_read(8'd12);
    endtask

    // mostly well-formed traffic over loaded vertices, some spare-mode noise
    task automatic test_random(input int count, input int tx_pct, input int rx_pct,
                               input logic unit);
        int sent;
        int pick;
        sent = 0;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        write_normalize(unit);
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_item(MODE_SPARE, {16'($urandom), 32'($urandom), 32'($urandom)});
            else
            begin
                if (pick < 30)
                    send_load(8'($urandom), rand_coord(), rand_coord(), rand_coord());
                else if (pick < 75)
                    send_face(rand_loaded(), rand_loaded(),
                              $urandom_range(0, 9) == 0 ? 8'd0 : rand_loaded());
                else
                    send_read(rand_loaded());
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_raw();
        test_saturation();
        test_normalized();
        test_random(70, 21, 78, 1'b1);
        test_random(70, 78, 21, 1'b0);
        test_random(70, 0, 0, 1'b1);
        s_tvalid <= 1'b0;
        while (pending_normals.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_normals.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
